### rtl/core/odo_pkg.sv
package odo_pkg;

    localparam int DW          = 32;
    localparam int MUL_STEPS   = 32;
    localparam int MOD_STEPS   = 33;
    localparam int ATAN_LEN    = 30;
    localparam int PI_Q16      = 205887;
    localparam int HALF_PI_Q16 = 102944;
    localparam int TWO_PI_Q16  = 411775;
    localparam int GAIN_Q30    = 652032874;

    localparam logic [1:0] REG_COUNT_SCALE = 2'd0;
    localparam logic [1:0] REG_INV_TRACK   = 2'd1;
    localparam logic [1:0] REG_SAMPLE_RATE = 2'd2;

    typedef struct packed {
        logic        start;
        logic [32:0] a;
        logic [31:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        start;
        logic [32:0] dividend;
    } t_mod_req;

    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'h3243F6A8;
            5'd1:  r = 32'h1DAC6705;
            5'd2:  r = 32'h0FADBAFC;
            5'd3:  r = 32'h07F56EA6;
            5'd4:  r = 32'h03FEAB76;
            5'd5:  r = 32'h01FFD55B;
            5'd6:  r = 32'h00FFFAAA;
            5'd7:  r = 32'h007FFF55;
            5'd8:  r = 32'h003FFFEA;
            5'd9:  r = 32'h001FFFFD;
            5'd10: r = 32'h000FFFFF;
            5'd11: r = 32'h0007FFFF;
            5'd12: r = 32'h0003FFFF;
            5'd13: r = 32'h0001FFFF;
            5'd14: r = 32'h0000FFFF;
            5'd15: r = 32'h00007FFF;
            5'd16: r = 32'h00003FFF;
            5'd17: r = 32'h00001FFF;
            5'd18: r = 32'h00000FFF;
            5'd19: r = 32'h000007FF;
            5'd20: r = 32'h000003FF;
            5'd21: r = 32'h000001FF;
            5'd22: r = 32'h000000FF;
            5'd23: r = 32'h0000007F;
            5'd24: r = 32'h0000003F;
            5'd25: r = 32'h0000001F;
            5'd26: r = 32'h0000000F;
            5'd27: r = 32'h00000008;
            5'd28: r = 32'h00000004;
            5'd29: r = 32'h00000002;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat_dw(input logic signed [51:0] v);
        logic signed [51:0] hi;
        logic signed [51:0] lo;
        hi = 52'sd2147483647;
        lo = -52'sd2147483648;
        if (v > hi) return 32'sh7FFFFFFF;
        if (v < lo) return 32'sh80000000;
        return v[31:0];
    endfunction

    // magnitude of a signed value, |v| < 2^33
    function automatic logic [32:0] mag33(input logic signed [33:0] v);
        logic signed [33:0] n;
        n = -v;
        return v[33] ? n[32:0] : v[32:0];
    endfunction

    // v / 2 rounded to nearest, ties away from zero, saturated
    function automatic logic signed [31:0] half_round(input logic signed [32:0] v);
        logic [32:0] m;
        logic [32:0] r;
        logic signed [51:0] s;
        m = mag33(34'(v));
        r = (m >> 1) + 33'(m[0]);
        s = v[32] ? -$signed({19'd0, r}) : $signed({19'd0, r});
        return sat_dw(s);
    endfunction

endpackage

### rtl/core/odo_mul.sv
module odo_mul
    import odo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mul_req    i_req,
    output logic        o_done,
    output logic [64:0] o_prod
);

    logic [32:0] r_a;
    logic [32:0] r_hi;
    logic [31:0] r_lo;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] n_sum;

    // shift-add, one multiplier bit per cycle, LSB first
    always_comb begin
        n_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : 34'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.a;
                r_hi   <= '0;
                r_lo   <= i_req.b;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_hi  <= n_sum[33:1];
                r_lo  <= {n_sum[0], r_lo[31:1]};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

### rtl/core/odo_mod.sv
module odo_mod
    import odo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mod_req    i_req,
    output logic        o_done,
    output logic [18:0] o_rem
);

    logic [32:0] r_q;
    logic [18:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [19:0] n_t;
    logic [19:0] n_rem;

    // restoring remainder by 2*pi, one dividend bit per cycle
    always_comb begin
        n_t   = {r_rem, r_q[32]};
        n_rem = (n_t >= 20'(TWO_PI_Q16)) ? n_t - 20'(TWO_PI_Q16) : n_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_q    <= i_req.dividend;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[31:0], 1'b0};
                r_rem <= n_rem[18:0];
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(MOD_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### rtl/core/odo_cordic.sv
module odo_cordic
    import odo_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [19:0] i_heading,
    output logic               o_valid,
    output logic signed [33:0] o_cos,
    output logic signed [33:0] o_sin
);

    localparam int N  = (STEPS < ATAN_LEN) ? STEPS : ATAN_LEN;
    localparam int CW = $clog2(N);

    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [33:0] r_z;
    logic [CW-1:0]      r_i;
    logic               r_neg;
    logic               r_busy;
    logic               r_valid;
    logic signed [20:0] n_h;
    logic               n_neg;
    logic signed [33:0] n_dx;
    logic signed [33:0] n_dy;
    logic signed [33:0] n_at;

    always_comb begin
        n_h   = 21'(i_heading);
        n_neg = 1'b0;
        // fold into +-pi/2, results negated when folded
        if (n_h > 21'sd102944) begin
            n_h   = n_h - 21'sd205887;
            n_neg = 1'b1;
        end else if (n_h < -21'sd102944) begin
            n_h   = n_h + 21'sd205887;
            n_neg = 1'b1;
        end
        n_dx = r_y >>> r_i;
        n_dy = r_x >>> r_i;
        n_at = $signed({2'b00, atan_q30(5'(r_i))});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_start) begin
                r_x     <= 34'sd652032874;
                r_y     <= '0;
                r_z     <= 34'(n_h) <<< 14;
                r_neg   <= n_neg;
                r_i     <= '0;
                r_busy  <= 1'b1;
                r_valid <= 1'b0;
            end else if (r_busy) begin
                if (r_z >= 0) begin
                    r_x <= r_x - n_dx;
                    r_y <= r_y + n_dy;
                    r_z <= r_z - n_at;
                end else begin
                    r_x <= r_x + n_dx;
                    r_y <= r_y - n_dy;
                    r_z <= r_z + n_at;
                end
                if (r_i == CW'(N - 1)) begin
                    r_busy  <= 1'b0;
                    r_valid <= 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_cos   = r_neg ? -r_x : r_x;
    assign o_sin   = r_neg ? -r_y : r_y;

endmodule

### rtl/core/diff_drive_odometry_unit.sv
// Differential-drive odometry. Each input item carries the right and left
// encoder counts; the block returns one item with pose (x, y, heading) and
// the wheel, linear and angular speeds, all Q16.16 but the heading (Q3.16).
// One item is worked on at a time: its steps are eight products on a single
// bit-serial multiplier and a bit-serial heading wrap by 2*pi, while the
// sine/cosine rotation runs alongside. A finished result waits in an output
// register while the next item is taken. Registers: count_scale at 0x0,
// inv_track_width at 0x4, sample_rate at 0x8; write them only while the
// block is idle.
module diff_drive_odometry_unit
    import odo_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [31:0] right_count, [63:32] left_count
    input  logic [63:0]  i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [31:0] x_pos, [63:32] y_pos, [82:64] heading, [114:83] linear_speed,
    // [146:115] angular_speed, [178:147] right_speed, [210:179] left_speed
    output logic [215:0] o_m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_DR, S_DL, S_DELTA, S_VR, S_VL, S_ANG, S_DTH,
        S_PX, S_PY, S_HEAD, S_OUT
    } t_state;

    t_state             r_state;
    logic               r_issued;
    logic signed [31:0] r_rc, r_lc;
    logic signed [31:0] r_dist_r, r_dist_l, r_prev_r, r_prev_l;
    logic signed [31:0] r_dr, r_dl, r_vr, r_vl, r_lin, r_ang, r_dth;
    logic signed [31:0] r_px, r_py;
    logic signed [19:0] r_hd;
    logic               r_ds_neg;
    logic [31:0]        r_dsm;
    logic               r_hneg;
    logic [31:0]        r_count_scale, r_inv_track;
    logic [15:0]        r_sample_rate;
    logic               r_out_valid;
    logic [215:0]       r_out_data;

    t_mul_req           n_mul;
    t_mod_req           n_mod;
    logic               n_neg;
    logic               mul_done, mod_done;
    logic [64:0]        mul_prod;
    logic [18:0]        mod_rem;
    logic               cor_valid;
    logic signed [33:0] cor_cos, cor_sin;
    logic               s_accept, n_is_mul;
    logic [49:0]        n_rnd;
    logic signed [51:0] n_val;
    logic signed [31:0] n_sat, n_ds, n_pose, n_dr, n_dl;
    logic signed [32:0] n_hsum;
    logic signed [20:0] n_h;

    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_mul    = '0;
        n_neg    = 1'b0;
        n_is_mul = 1'b1;
        unique case (r_state)
            S_DR: begin
                n_mul.a = mag33(34'(r_rc));
                n_mul.b = r_count_scale;
                n_neg   = r_rc[31];
            end
            S_DL: begin
                // left encoder is mirrored: sign inverted
                n_mul.a = mag33(34'(r_lc));
                n_mul.b = r_count_scale;
                n_neg   = ~r_lc[31];
            end
            S_VR: begin
                n_mul.a = mag33(34'(r_dr));
                n_mul.b = {16'd0, r_sample_rate};
                n_neg   = r_dr[31];
            end
            S_VL: begin
                n_mul.a = mag33(34'(r_dl));
                n_mul.b = {16'd0, r_sample_rate};
                n_neg   = r_dl[31];
            end
            S_ANG: begin
                n_mul.a = mag33(34'(r_vr) - 34'(r_vl));
                n_mul.b = r_inv_track;
                n_neg   = r_vr < r_vl;
            end
            S_DTH: begin
                n_mul.a = mag33(34'(r_dr) - 34'(r_dl));
                n_mul.b = r_inv_track;
                n_neg   = r_dr < r_dl;
            end
            S_PX: begin
                n_mul.a = mag33(cor_cos);
                n_mul.b = r_dsm;
                n_neg   = cor_cos[33] ^ r_ds_neg;
            end
            S_PY: begin
                n_mul.a = mag33(cor_sin);
                n_mul.b = r_dsm;
                n_neg   = cor_sin[33] ^ r_ds_neg;
            end
            default: n_is_mul = 1'b0;
        endcase
        n_mul.start = n_is_mul && !r_issued &&
                      ((r_state != S_PX && r_state != S_PY) || cor_valid);

        case (r_state)
            S_VR, S_VL: n_rnd = mul_prod[49:0];
            S_PX, S_PY: n_rnd = 50'(mul_prod[64:30]) + 50'(mul_prod[29]);
            default:    n_rnd = 50'(mul_prod[64:16]) + 50'(mul_prod[15]);
        endcase
        n_val  = n_neg ? -$signed({2'b00, n_rnd}) : $signed({2'b00, n_rnd});
        n_sat  = sat_dw(n_val);
        n_pose = sat_dw(n_val + 52'((r_state == S_PX) ? r_px : r_py));

        n_dr = sat_dw(52'(r_dist_r) - 52'(r_prev_r));
        n_dl = sat_dw(52'(r_dist_l) - 52'(r_prev_l));
        n_ds = half_round(33'(r_dr) + 33'(r_dl));

        n_hsum       = 33'(r_hd) + 33'(r_dth);
        n_mod.start  = (r_state == S_HEAD) && !r_issued;
        n_mod.dividend = mag33(34'(n_hsum));
        n_h = r_hneg ? -$signed({2'b00, mod_rem}) : $signed({2'b00, mod_rem});
        if (n_h > 21'sd205887) n_h = n_h - 21'sd411775;
        if (n_h < -21'sd205887) n_h = n_h + 21'sd411775;
    end

    odo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_mul),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    odo_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_mod),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    odo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (s_accept),
        .i_heading (r_hd),
        .o_valid   (cor_valid),
        .o_cos     (cor_cos),
        .o_sin     (cor_sin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_prev_r    <= '0;
            r_prev_l    <= '0;
            r_px        <= '0;
            r_py        <= '0;
            r_hd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready && r_state != S_OUT) r_out_valid <= 1'b0;
            if (n_mul.start || n_mod.start) r_issued <= 1'b1;
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_rc    <= i_s_tdata[31:0];
                        r_lc    <= i_s_tdata[63:32];
                        r_state <= S_DR;
                    end
                end
                S_DELTA: begin
                    r_dr     <= n_dr;
                    r_dl     <= n_dl;
                    r_prev_r <= r_dist_r;
                    r_prev_l <= r_dist_l;
                    r_state  <= S_VR;
                end
                S_HEAD: begin
                    if (!r_issued) r_hneg <= n_hsum[32];
                    if (r_issued && mod_done) begin
                        r_issued <= 1'b0;
                        r_hd     <= n_h[19:0];
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_data  <= {5'd0, r_vl, r_vr, r_ang, r_lin,
                                        r_hd[18:0], r_py, r_px};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    if (r_issued && mul_done) begin
                        r_issued <= 1'b0;
                        case (r_state)
                            S_DR: begin
                                r_dist_r <= n_sat;
                                r_state  <= S_DL;
                            end
                            S_DL: begin
                                r_dist_l <= n_sat;
                                r_state  <= S_DELTA;
                            end
                            S_VR: begin
                                r_vr     <= n_sat;
                                r_ds_neg <= n_ds[31];
                                r_dsm    <= n_ds[31] ? 32'(-n_ds) : 32'(n_ds);
                                r_state  <= S_VL;
                            end
                            S_VL: begin
                                r_vl    <= n_sat;
                                r_state <= S_ANG;
                            end
                            S_ANG: begin
                                r_ang   <= n_sat;
                                r_lin   <= half_round(33'(r_vr) + 33'(r_vl));
                                r_state <= S_DTH;
                            end
                            S_DTH: begin
                                r_dth   <= n_sat;
                                r_state <= S_PX;
                            end
                            S_PX: begin
                                r_px    <= n_pose;
                                r_state <= S_PY;
                            end
                            default: begin
                                r_py    <= n_pose;
                                r_state <= S_HEAD;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_scale <= 32'd69578;
            r_inv_track   <= 32'd327680;
            r_sample_rate <= 16'd250;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_COUNT_SCALE: r_count_scale <= pwdata;
                REG_INV_TRACK:   r_inv_track   <= pwdata;
                REG_SAMPLE_RATE: r_sample_rate <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_COUNT_SCALE: prdata = r_count_scale;
            REG_INV_TRACK:   prdata = r_inv_track;
            REG_SAMPLE_RATE: prdata = {16'd0, r_sample_rate};
            default:         prdata = '0;
        endcase
    end

    assign pready = 1'b1;

endmodule

### rtl/core/odo_checker.sv
module odo_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [215:0] o_m_tdata,
    input logic         pready
);

    logic signed [18:0] heading;
    assign heading = o_m_tdata[82:64];

    // one item in flight: no second accept right after the first
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second item taken while one is in work");

    a_heading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (heading >= -19'sd205887 && heading <= 19'sd205887))
        else $error("heading outside +-pi");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result item dropped or changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && o_s_tready && pready))
        else $error("bad state after reset");

endmodule

bind diff_drive_odometry_unit odo_checker u_odo_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .pready     (pready)
);

### verif/diff_drive_odometry_unit_tb.sv
`timescale 1ns / 100ps

module diff_drive_odometry_unit_tb;
    import odo_pkg::*;

    typedef struct {
        logic signed [31:0] x_pos;
        logic signed [31:0] y_pos;
        logic signed [18:0] heading;
        logic signed [31:0] linear_speed;
        logic signed [31:0] angular_speed;
        logic signed [31:0] right_speed;
        logic signed [31:0] left_speed;
    } odo_result_t;

    // 64-bit fixed-point helpers used by the odometry predictor
    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // (a * b) / 2^k, round to nearest, ties away from zero
    function automatic longint scale_round(input longint a, input longint unsigned b,
                                           input int k);
        logic neg;
        longint unsigned m;
        neg = a < 0;
        m = neg ? 64'(-a) : 64'(a);
        m = m * b;
        m = (m >> k) + ((m >> (k - 1)) & 64'd1);
        if (m > 64'h7FFF_FFFF_FFFF_FFFF) m = 64'h7FFF_FFFF_FFFF_FFFF;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint floor_shift(input longint v, input int k);
        return v >>> k;
    endfunction

    class odo_scoreboard;
        longint unsigned count_scale;
        longint unsigned inv_track;
        longint          sample_rate;
        longint prev_r, prev_l, px, py, hd;
        odo_result_t pending_results[$];
        int errors;

        function void reset_state();
            count_scale = 69578; inv_track = 327680; sample_rate = 250;
            prev_r = 0; prev_l = 0; px = 0; py = 0; hd = 0;
        endfunction

        function void set_reg(input logic [1:0] idx, input logic [31:0] val);
            case (idx)
                REG_COUNT_SCALE: count_scale = val;
                REG_INV_TRACK:   inv_track = val;
                REG_SAMPLE_RATE: sample_rate = val[15:0];
                default: ;
            endcase
        endfunction

        function void sin_cos(input longint h, output longint c, output longint s);
            logic neg;
            longint x, y, z, dx, dy;
            neg = 0; x = GAIN_Q30; y = 0;
            if (h > HALF_PI_Q16) begin
                h -= PI_Q16; neg = 1;
            end else if (h < -HALF_PI_Q16) begin
                h += PI_Q16; neg = 1;
            end
            z = h * 16384;
            for (int i = 0; i < 16; i++) begin
                dx = floor_shift(y, i);
                dy = floor_shift(x, i);
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_q30(5'(i));
                end else begin
                    x += dx; y -= dy; z += atan_q30(5'(i));
                end
            end
            c = neg ? -x : x;
            s = neg ? -y : y;
        endfunction

        function void note_sample(input logic [31:0] rcnt, input logic [31:0] lcnt);
            longint dr, dl, d_r, d_l, v_r, v_l, lin, ang, ds, dth, c, s, dsm, sx, sy, h;
            odo_result_t r;
            dr = clamp32(scale_round(longint'($signed(rcnt)), count_scale, 16));
            dl = clamp32(-scale_round(longint'($signed(lcnt)), count_scale, 16));
            d_r = clamp32(dr - prev_r);
            d_l = clamp32(dl - prev_l);
            v_r = clamp32(d_r * sample_rate);
            v_l = clamp32(d_l * sample_rate);
            lin = clamp32(scale_round(v_r + v_l, 1, 1));
            ang = clamp32(scale_round(v_r - v_l, inv_track, 16));
            ds = clamp32(scale_round(d_r + d_l, 1, 1));
            dth = clamp32(scale_round(d_r - d_l, inv_track, 16));
            dsm = ds < 0 ? -ds : ds;
            sin_cos(hd, c, s);
            sx = scale_round(c, dsm, 30);
            sy = scale_round(s, dsm, 30);
            if (ds < 0) begin
                sx = -sx; sy = -sy;
            end
            px = clamp32(px + sx);
            py = clamp32(py + sy);
            h = (hd + dth) % TWO_PI_Q16;
            if (h > PI_Q16) h -= TWO_PI_Q16;
            if (h < -PI_Q16) h += TWO_PI_Q16;
            hd = h;
            prev_r = dr; prev_l = dl;
            r.x_pos = px[31:0]; r.y_pos = py[31:0]; r.heading = hd[18:0];
            r.linear_speed = lin[31:0]; r.angular_speed = ang[31:0];
            r.right_speed = v_r[31:0]; r.left_speed = v_l[31:0];
            pending_results.push_back(r);
        endfunction

        function void check_one(input string nm, input logic [31:0] e, input logic [31:0] a);
            if (e !== a) begin
                $display("%0t: %s mismatch expected %h actual %h", $time, nm, e, a);
                errors++;
            end
        endfunction

        function void check_result(input logic [215:0] d);
            odo_result_t e;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item expected none actual %h", $time, d);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            check_one("x_pos", e.x_pos, d[31:0]);
            check_one("y_pos", e.y_pos, d[63:32]);
            check_one("heading", 32'(e.heading[18:0]), 32'(d[82:64]));
            check_one("linear_speed", e.linear_speed, d[114:83]);
            check_one("angular_speed", e.angular_speed, d[146:115]);
            check_one("right_speed", e.right_speed, d[178:147]);
            check_one("left_speed", e.left_speed, d[210:179]);
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    // [31:0] right_count, [63:32] left_count
    logic [63:0]  i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    // [31:0] x_pos, [63:32] y_pos, [82:64] heading, [114:83] linear_speed,
    // [146:115] angular_speed, [178:147] right_speed, [210:179] left_speed
    logic [215:0] o_m_tdata;
    logic         psel, penable, pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    odo_scoreboard odo_sb;
    int           idle_cycles;
    logic         sink_on;

    diff_drive_odometry_unit dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        if ($urandom_range(9) < 7) return $urandom_range(1);
        return $urandom_range(40, 5);
    endfunction

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        odo_sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    // tvalid stays high after the accept until a call with a gap or drain drops it
    task automatic send_sample(input logic [31:0] rc, input logic [31:0] lc, input int gap);
        if (gap > 0) begin
            i_s_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tdata <= {lc, rc};
        do @(posedge i_clk); while (!o_s_tready);
        odo_sb.note_sample(rc, lc);
    endtask

    // wait for all results, then let the block fully settle
    task automatic drain();
        i_s_tvalid <= 0;
        while (odo_sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_count();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'h7FFF_FFFF - $urandom_range(3);
            2: return 32'h8000_0000 + $urandom_range(3);
            default: return 32'($signed($urandom_range(400000)) - 200000);
        endcase
    endfunction

    // receiver side: random stalls, sometimes long stretches always ready
    initial begin
        i_m_tready = 0;
        sink_on = 0;
        @(posedge i_clk);
        forever begin
            int n;
            if ($urandom_range(3) == 0) begin
                i_m_tready <= 1;
                n = $urandom_range(300, 50);
            end else begin
                i_m_tready <= ~i_m_tready;
                n = i_m_tready ? gap_len() + 1 : $urandom_range(3) + 1;
            end
            repeat (n) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) odo_sb.check_result(o_m_tdata);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("diff_drive_odometry_unit_tb failed");
            $finish;
        end
    end

    initial begin
        logic [31:0] rc, lc;
        odo_sb = new();
        odo_sb.reset_state();
        idle_cycles = 0;
        i_rst_n = 0; i_s_tvalid = 0; i_s_tdata = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: count extremes, zero, reversal, spin in place
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1);
        send_sample(0, 0, 0);
        send_sample(32'hFFFF_FFFF, 32'h0000_0001, 3);
        for (int i = 1; i <= 6; i++) send_sample(32'(i * 30000), 32'(-i * 30000), 0);
        for (int i = 1; i <= 4; i++) send_sample(32'(i * 9000), 32'(i * 9000), 0);
        drain();

        // zero sample rate, maximum scale and track factor
        apb_write(REG_SAMPLE_RATE, 0);
        apb_write(REG_COUNT_SCALE, 32'hFFFF_FFFF);
        apb_write(REG_INV_TRACK, 32'hFFFF_FFFF);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_sample(32'h0001_0000, 32'hFFFF_0000, 0);
        send_sample(32'h8000_0000, 32'h8000_0000, 0);
        drain();

        // maximum rate, zero scale, zero track factor
        apb_write(REG_SAMPLE_RATE, 16'hFFFF);
        apb_write(REG_COUNT_SCALE, 0);
        apb_write(REG_INV_TRACK, 0);
        send_sample(32'h1234_5678, 32'h8765_4321, 0);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 0);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    apb_write(REG_COUNT_SCALE, 69578);
                    apb_write(REG_INV_TRACK, 327680);
                    apb_write(REG_SAMPLE_RATE, 250);
                end
                4: begin
                    apb_write(REG_COUNT_SCALE, 32'hFFFF_FFFF);
                    apb_write(REG_INV_TRACK, 32'hFFFF_FFFF);
                    apb_write(REG_SAMPLE_RATE, 1);
                end
                default: begin
                    apb_write(REG_COUNT_SCALE, $urandom());
                    apb_write(REG_INV_TRACK, $urandom_range(32'h0010_0000));
                    apb_write(REG_SAMPLE_RATE, $urandom_range(65535));
                end
            endcase
            rc = 0; lc = 0;
            for (int n = 0; n < 90; n++) begin
                // mostly smooth motion so heading sweeps all quadrants
                if ($urandom_range(4) == 0) begin
                    rc = rand_count(); lc = rand_count();
                end else begin
                    rc = rc + 32'($signed($urandom_range(6000)) - 2000);
                    lc = lc + 32'($signed($urandom_range(6000)) - 4000);
                end
                send_sample(rc, lc, ($urandom_range(4) == 0) ? 0 : gap_len());
            end
            drain();
        end

        if (odo_sb.errors == 0 && odo_sb.pending_results.size() == 0)
            $display("diff_drive_odometry_unit_tb passed");
        else
            $display("diff_drive_odometry_unit_tb failed");
        $finish;
    end

endmodule

### diff_drive_odometry_unit.f
rtl/core/odo_pkg.sv
rtl/core/odo_mul.sv
rtl/core/odo_mod.sv
rtl/core/odo_cordic.sv
rtl/core/diff_drive_odometry_unit.sv
rtl/core/odo_checker.sv
verif/diff_drive_odometry_unit_tb.sv
